FILE: rtl/ssl_pkg.sv
// ssl_pkg: shared types, opcodes and sizes of the swap slot table
// no dependencies; used by every module in rtl
package ssl_pkg;

    localparam int SLOT_COUNT = 2048;
    localparam int PAGE_BYTES = 4096;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int OPCODE_W  = 3;
    localparam int ADDR_W    = 32;
    localparam int ID_W      = 8;
    localparam int SEL_W     = 11;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 11;
    localparam int OFFSET_W  = 23;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;
    localparam int PROD_W    = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOOKUP     = 3'd0,
        OP_PLACE_OUT  = 3'd1,
        OP_SET_SLOT   = 3'd2,
        OP_FREE_OWNER = 3'd3,
        OP_FREE_ADDR  = 3'd4,
        OP_CLEAR_ALL  = 3'd5
    } opcode_t;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;

    // contents of one swap slot
    typedef struct packed {
        logic              free;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   owner;
    } slot_t;

endpackage

FILE: rtl/swap_slot_table.sv
// swap_slot_table: top level, a ring of slot cells and its sequencer
// depends on ssl_pkg, ssl_cell, ssl_ctrl
//
// Each item makes one full turn of a ring of SLOT_COUNT slot cells, one slot
// passing the head cell per clock, plus one more turn of the ring when place
// out claims a free slot. The turn of the ring sets how long an item takes.
// A new item is taken once the previous result sits in the output register.
// Reset clears every slot to free; no clearing pass follows.
module swap_slot_table
    import ssl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // virtual_address [31:0], space_id [39:32], slot_select [50:40]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode [2:0]
    input  logic [OPCODE_W-1:0]  s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status [1:0], slot_index [12:2], byte_offset [35:13]
    output logic [M_TDATA_W-1:0] m_tdata
);

    slot_t ring [SLOT_COUNT];
    slot_t tail;
    logic  shift;

    // head cell feeds the sequencer, its updated slot enters at the tail
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        ssl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift    (shift),
            .slot_in  ((g == SLOT_COUNT - 1) ? tail : ring[(g + 1) % SLOT_COUNT]),
            .slot_out (ring[g])
        );
    end

    ssl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (s_tuser),
        .s_addr   (s_tdata[ADDR_W-1:0]),
        .s_id     (s_tdata[ADDR_W+ID_W-1:ADDR_W]),
        .s_sel    (s_tdata[ADDR_W+ID_W+SEL_W-1:ADDR_W+ID_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .head     (ring[0]),
        .tail     (tail),
        .shift    (shift)
    );

endmodule

FILE: rtl/ssl_cell.sv
// ssl_cell: one slot of the rotating slot ring
// depends on ssl_pkg
module ssl_cell
    import ssl_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  shift,
    input  slot_t slot_in,
    output slot_t slot_out
);

    slot_t slot_reg;

    // take the neighbor's slot on every shift, reset to a free empty slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '{free: 1'b1, addr: '0, owner: '0};
        end else if (shift) begin
            slot_reg <= slot_in;
        end
    end

    assign slot_out = slot_reg;

endmodule

FILE: rtl/ssl_ctrl.sv
// ssl_ctrl: sequencer that works on the slot at the head of the ring
// depends on ssl_pkg
module ssl_ctrl
    import ssl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [OPCODE_W-1:0]  s_opcode,
    input  logic [ADDR_W-1:0]    s_addr,
    input  logic [ID_W-1:0]      s_id,
    input  logic [SEL_W-1:0]     s_sel,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  slot_t                head,
    output slot_t                tail,
    output logic                 shift
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLAIM,
        S_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [OPCODE_W-1:0]   op_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ID_W-1:0]       id_reg;
    logic [SEL_W-1:0]      sel_reg;
    logic                  found_reg, found_next;
    logic [SLOT_W-1:0]     found_idx_reg, found_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [SLOT_W-1:0]     free_idx_reg, free_idx_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  last_slot;
    logic                  addr_match;
    logic                  sel_in_range;
    logic [PROD_W-1:0]     offset_prod;
    slot_t                 released;

    assign last_slot    = (cnt_reg == SLOT_W'(SLOT_COUNT - 1));
    assign addr_match   = !head.free && (head.addr == addr_reg);
    assign sel_in_range = (32'(sel_reg) < SLOT_COUNT);
    assign released     = '{free: 1'b1, addr: '0, owner: '0};
    assign shift        = (state_reg == S_SCAN) || (state_reg == S_CLAIM);
    assign s_tready     = (state_reg == S_IDLE);
    assign offset_prod  = PROD_W'(res_slot_reg) * PROD_W'(PAGE_BYTES);

    // head slot update and scan bookkeeping
    always_comb begin
        tail            = head;
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        case (state_reg)
            S_SCAN: begin
                cnt_next = last_slot ? '0 : cnt_reg + 1'b1;
                case (op_reg)
                    OP_LOOKUP, OP_PLACE_OUT: begin
                        if (addr_match && !found_reg) begin
                            found_next     = 1'b1;
                            found_idx_next = cnt_reg;
                        end
                        if (head.free && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = cnt_reg;
                        end
                    end
                    OP_SET_SLOT: begin
                        if (32'(cnt_reg) == 32'(sel_reg)) begin
                            tail.addr  = addr_reg;
                            tail.owner = id_reg;
                        end
                    end
                    OP_FREE_OWNER: begin
                        if (head.owner == id_reg) tail = released;
                    end
                    OP_FREE_ADDR: begin
                        if (addr_match) tail = released;
                    end
                    OP_CLEAR_ALL: begin
                        tail = released;
                    end
                    default: begin
                    end
                endcase
                // settle the result after the last slot has passed
                if (last_slot) begin
                    res_status_next = ST_DONE;
                    res_slot_next   = '0;
                    state_next      = S_RESULT;
                    case (op_reg)
                        OP_LOOKUP: begin
                            if (found_next) res_slot_next = found_idx_next;
                            else res_status_next = ST_NOT_FOUND;
                        end
                        OP_PLACE_OUT: begin
                            if (found_next) begin
                                res_slot_next = found_idx_next;
                            end else if (free_found_next) begin
                                res_slot_next = free_idx_next;
                                state_next    = S_CLAIM;
                            end else begin
                                res_status_next = ST_NO_SPACE;
                            end
                        end
                        OP_SET_SLOT: begin
                            if (sel_in_range) res_slot_next = SLOT_W'(sel_reg);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLAIM: begin
                cnt_next = last_slot ? '0 : cnt_reg + 1'b1;
                if (cnt_reg == free_idx_reg) tail.free = 1'b0;
                if (last_slot) state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            end
            default: begin
                if (s_tvalid) begin
                    state_next      = S_SCAN;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                end
            end
        endcase
    end

    // state, working registers and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            if (state_reg == S_RESULT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        found_idx_reg  <= found_idx_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg   <= s_opcode;
            addr_reg <= s_addr;
            id_reg   <= s_id;
            sel_reg  <= s_sel;
        end
        if (state_reg == S_RESULT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= M_TDATA_W'({offset_prod[OFFSET_W-1:0],
                                       INDEX_W'(res_slot_reg), res_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // idle always leaves the ring in its home position
    a_idle_home: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> cnt_reg == '0)
        else $error("ring not at home position while idle");

    // a claim pass only follows a scan with no match and a free slot
    a_claim_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLAIM |-> !found_reg && free_found_reg)
        else $error("claim pass without a free slot");

    // once found during a scan, the match is kept
    a_found_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN && found_reg && !last_slot |=> found_reg)
        else $error("address match lost during scan");

endmodule
